// ----- sv/vrt_pkg.sv -----
// Shared types and constants for the voxel ray traversal core.
package vrt_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_RESP
    } t_state;

    localparam logic       CMD_START = 1'b0;
    localparam logic       CMD_STEP  = 1'b1;

    localparam logic [1:0] STAT_PROBE  = 2'd0;
    localparam logic [1:0] STAT_HIT    = 2'd1;
    localparam logic [1:0] STAT_MISS   = 2'd2;
    localparam logic [1:0] STAT_NO_RAY = 2'd3;

    localparam logic [2:0] FACE_POS_Y = 3'd2;

    localparam int DIR_FRAC = 14;
    localparam int DIST_W   = 48;
    localparam int STEP_W   = 32;

    localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
    localparam logic [STEP_W-1:0] STEP_INF = {STEP_W{1'b1}};

endpackage

// ----- sv/voxel_ray_traversal_core.sv -----
// Voxel ray traversal core: fixed-point 3D DDA walk with a shared serial divider.
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_ready   i_cmd, i_origin_*, i_dir_*, i_max_distance,
//                                                 i_block_solid
//   out      source     o_out_valid / i_out_ready o_status, o_cell_*, o_before_*, o_face,
//                                                 o_hit_distance
//
// Step beat: accept, then result held until taken.
// Start beat: runs on one restoring divider
// (one quotient bit per cycle) shared by the six crossing divisions.
// One beat at a time: o_in_ready is low from accept until the result is taken.
// Reset is synchronous, active low; it clears the sequencer and the active-ray flag.
module voxel_ray_traversal_core #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [31:0] i_origin_x,
    input  logic [31:0] i_origin_y,
    input  logic [31:0] i_origin_z,
    input  logic [15:0] i_dir_x,
    input  logic [15:0] i_dir_y,
    input  logic [15:0] i_dir_z,
    input  logic [30:0] i_max_distance,
    input  logic        i_block_solid,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_cell_x,
    output logic [15:0] o_cell_y,
    output logic [15:0] o_cell_z,
    output logic [15:0] o_before_x,
    output logic [15:0] o_before_y,
    output logic [15:0] o_before_z,
    output logic [2:0]  o_face,
    output logic [30:0] o_hit_distance
);

    localparam int NUM_W = FRAC_BITS + vrt_pkg::DIR_FRAC + 1;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int REM_W = 17;
    localparam int DW    = vrt_pkg::DIST_W;
    localparam int SW    = vrt_pkg::STEP_W;

    vrt_pkg::t_state r_state, n_state;

    logic signed [COORD_BITS-1:0] r_cur [3];
    logic signed [COORD_BITS-1:0] r_prev [3];
    logic [DW-1:0]                r_nc [3];
    logic [SW-1:0]                r_cs [3];
    logic [2:0]                   r_neg;
    logic [2:0]                   r_dz;
    logic [FRAC_BITS:0]           r_b [3];
    logic [15:0]                  r_mag [3];
    logic [DW-1:0]                r_dist;
    logic [2:0]                   r_face;
    logic [30:0]                  r_reach;
    logic                         r_active;

    logic [2:0]       r_k;
    logic [CNT_W-1:0] r_cnt;
    logic [REM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_q;

    logic [1:0]  r_o_status;
    logic [15:0] r_o_cell [3];
    logic [15:0] r_o_before [3];
    logic [2:0]  r_o_face;
    logic [30:0] r_o_dist;

    logic        in_acc;
    logic [31:0] org [3];
    logic [15:0] dir [3];

    // start-time per-axis values
    logic signed [COORD_BITS-1:0] st_cell [3];
    logic [FRAC_BITS:0]           st_b [3];
    logic [15:0]                  st_mag [3];

    // divider datapath
    logic [1:0]       dv_ax;
    logic [NUM_W-1:0] dv_num;
    logic [REM_W-1:0] dv_sh;
    logic [REM_W:0]   dv_trial;
    logic             dv_ge;
    logic [NUM_W-1:0] dv_q;

    // step datapath
    logic [1:0]                   sp_ax;
    logic [DW-1:0]                sp_t;
    logic [DW:0]                  sp_sum;
    logic [DW-1:0]                sp_nc;
    logic signed [COORD_BITS-1:0] sp_cell;
    logic                         sp_in_reach;

    assign in_acc = i_in_valid && o_in_ready;
    assign org[0] = i_origin_x;
    assign org[1] = i_origin_y;
    assign org[2] = i_origin_z;
    assign dir[0] = i_dir_x;
    assign dir[1] = i_dir_y;
    assign dir[2] = i_dir_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            st_cell[i] = COORD_BITS'($signed(org[i]) >>> FRAC_BITS);
            st_mag[i]  = dir[i][15] ? 16'(-dir[i]) : dir[i];
            if (dir[i][15]) begin
                st_b[i] = {1'b0, org[i][FRAC_BITS-1:0]};
            end else begin
                st_b[i] = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, org[i][FRAC_BITS-1:0]};
            end
        end
    end

    always_comb begin
        dv_ax = r_k[2:1];
        if (r_k[0]) begin
            dv_num = NUM_W'(1) << (FRAC_BITS + vrt_pkg::DIR_FRAC);
        end else begin
            dv_num = NUM_W'(r_b[dv_ax]) << vrt_pkg::DIR_FRAC;
        end
        dv_sh    = {r_rem[REM_W-2:0], r_q[NUM_W-1]};
        dv_trial = {1'b0, dv_sh} - (REM_W + 1)'(r_mag[dv_ax]);
        dv_ge    = !dv_trial[REM_W];
        dv_q     = {r_q[NUM_W-2:0], dv_ge};
    end

    always_comb begin
        priority if (r_nc[0] < r_nc[1] && r_nc[0] < r_nc[2]) begin
            sp_ax = 2'd0;
        end else if (r_nc[1] < r_nc[2]) begin
            sp_ax = 2'd1;
        end else begin
            sp_ax = 2'd2;
        end
        sp_t        = r_nc[sp_ax];
        sp_sum      = {1'b0, sp_t} + (DW + 1)'(r_cs[sp_ax]);
        sp_nc       = sp_sum[DW] ? vrt_pkg::DIST_INF : sp_sum[DW-1:0];
        sp_cell     = r_neg[sp_ax] ? r_cur[sp_ax] - 1'b1 : r_cur[sp_ax] + 1'b1;
        sp_in_reach = sp_t < DW'(r_reach);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vrt_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_cmd == vrt_pkg::CMD_START) ? vrt_pkg::S_DIV : vrt_pkg::S_RESP;
                end
            end
            vrt_pkg::S_DIV: begin
                if (r_cnt == CNT_W'(1) && r_k == 3'd5) begin
                    n_state = vrt_pkg::S_RESP;
                end
            end
            vrt_pkg::S_RESP: begin
                if (i_out_ready) begin
                    n_state = vrt_pkg::S_IDLE;
                end
            end
            default: n_state = vrt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vrt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (r_state == vrt_pkg::S_IDLE && in_acc) begin
            r_o_status <= vrt_pkg::STAT_NO_RAY;
            r_o_face   <= '0;
            r_o_dist   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_o_cell[i]   <= '0;
                r_o_before[i] <= '0;
            end
            if (i_cmd == vrt_pkg::CMD_START) begin
                for (int i = 0; i < 3; i++) begin
                    r_cur[i]  <= st_cell[i];
                    r_prev[i] <= st_cell[i];
                    r_b[i]    <= st_b[i];
                    r_mag[i]  <= st_mag[i];
                    r_neg[i]  <= dir[i][15];
                    r_dz[i]   <= (dir[i] == 16'd0);
                end
                r_dist  <= '0;
                r_face  <= vrt_pkg::FACE_POS_Y;
                r_reach <= i_max_distance;
                r_k     <= '0;
                r_cnt   <= '0;
            end else if (r_active) begin
                if (i_block_solid) begin
                    r_active   <= 1'b0;
                    r_o_status <= vrt_pkg::STAT_HIT;
                    r_o_face   <= r_face;
                    r_o_dist   <= r_dist[30:0];
                    for (int i = 0; i < 3; i++) begin
                        r_o_cell[i]   <= 16'(r_cur[i]);
                        r_o_before[i] <= 16'(r_prev[i]);
                    end
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        r_prev[i] <= r_cur[i];
                    end
                    r_cur[sp_ax] <= sp_cell;
                    r_nc[sp_ax]  <= sp_nc;
                    r_dist       <= sp_t;
                    r_face       <= {sp_ax, ~r_neg[sp_ax]};
                    if (sp_in_reach) begin
                        r_o_status <= vrt_pkg::STAT_PROBE;
                        for (int i = 0; i < 3; i++) begin
                            r_o_cell[i] <= (i == int'(sp_ax)) ? 16'(sp_cell) : 16'(r_cur[i]);
                        end
                    end else begin
                        r_active   <= 1'b0;
                        r_o_status <= vrt_pkg::STAT_MISS;
                    end
                end
            end
        end else if (r_state == vrt_pkg::S_DIV) begin
            if (r_cnt == '0) begin
                r_rem <= '0;
                r_q   <= dv_num;
                r_cnt <= CNT_W'(NUM_W);
            end else begin
                r_rem <= dv_ge ? dv_trial[REM_W-1:0] : dv_sh;
                r_q   <= dv_q;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_k <= r_k + 1'b1;
                    if (!r_k[0]) begin
                        r_nc[dv_ax] <= r_dz[dv_ax] ? vrt_pkg::DIST_INF : DW'(dv_q);
                    end else if (r_dz[dv_ax] || (64'(dv_q) > 64'(vrt_pkg::STEP_INF))) begin
                        r_cs[dv_ax] <= vrt_pkg::STEP_INF;
                    end else begin
                        r_cs[dv_ax] <= SW'(dv_q);
                    end
                    if (r_k == 3'd5) begin
                        if (r_reach != '0) begin
                            r_active   <= 1'b1;
                            r_o_status <= vrt_pkg::STAT_PROBE;
                            for (int i = 0; i < 3; i++) begin
                                r_o_cell[i] <= 16'(r_cur[i]);
                            end
                        end else begin
                            r_active   <= 1'b0;
                            r_o_status <= vrt_pkg::STAT_MISS;
                        end
                    end
                end
            end
        end
    end

    assign o_in_ready     = (r_state == vrt_pkg::S_IDLE);
    assign o_out_valid    = (r_state == vrt_pkg::S_RESP);
    assign o_status       = r_o_status;
    assign o_cell_x       = r_o_cell[0];
    assign o_cell_y       = r_o_cell[1];
    assign o_cell_z       = r_o_cell[2];
    assign o_before_x     = r_o_before[0];
    assign o_before_y     = r_o_before[1];
    assign o_before_z     = r_o_before[2];
    assign o_face         = r_o_face;
    assign o_hit_distance = r_o_dist;

endmodule

// ----- sv/vrt_checker.sv -----
// Port-level checks for the voxel ray traversal core, bound to the top level.
module vrt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [2:0]  o_face,
    input logic [30:0] o_hit_distance
);

    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a beat is in flight");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("ready while a result is pending");

    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |=> !o_out_valid)
        else $error("result repeated after accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("stalled result changed");

    a_hit_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != vrt_pkg::STAT_HIT |->
            o_face == 3'd0 && o_hit_distance == 31'd0)
        else $error("hit fields set on a non-hit result");

endmodule

bind voxel_ray_traversal_core vrt_checker u_vrt_checker (.*);
